[rtl/core/qeb_pkg.sv]
// ----------------------------------------------------------------------------
// qeb_pkg
// shared types and constants of the quadrature encoder with button block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qeb_pkg;

   localparam int TIME_BITS     = 32;
   localparam int CFG_BITS      = 16;
   localparam int RSP_POS_BITS  = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_IDLE     = 2'd1
   } qeb_csr_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } qeb_dir_type;

   typedef enum logic [1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } qeb_step_type;

   // indexed by {old pair, new pair}, phase a as the high bit of a pair
   localparam qeb_step_type STEP_TABLE [0:15] = '{
      STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
      STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
      STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
      STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
   };

   typedef struct packed {
      logic                 phase_a;
      logic                 phase_b;
      logic                 switch_level;
      logic [TIME_BITS-1:0] now_ms;
      logic                 poll_press;
   } qeb_sample_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] debounce_ms;
      logic [CFG_BITS-1:0] idle_ms;
   } qeb_cfg_type;

   typedef struct packed {
      logic signed [RSP_POS_BITS-1:0] position;
      qeb_dir_type                    direction;
      logic                           button_held;
      logic                           new_press;
   } qeb_result_type;

endpackage

`default_nettype wire

[rtl/core/qeb_core.sv]
// ----------------------------------------------------------------------------
// qeb_core
// decoder state and single-pass update for one pin sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qeb_core
   import qeb_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           sample_valid,
   input  wire qeb_sample_type sample,
   input  wire qeb_cfg_type    cfg,
   output qeb_result_type      result
);

   logic [1:0]                      pair_ff, pair_in;
   logic signed [POSITION_BITS-1:0] count_ff, count_in;
   qeb_dir_type                     dir_ff, dir_in;
   logic [TIME_BITS-1:0]            last_time_ff, last_time_in;
   logic                            last_sw_ff, last_sw_in;
   logic                            held_ff, held_in;
   logic                            reported_ff, reported_in;

   logic [1:0]           pair_new;
   qeb_step_type         step;
   logic [TIME_BITS-1:0] gap;
   logic                 take_step;
   logic                 fresh;

   always_comb begin
      pair_new  = {sample.phase_a, sample.phase_b};
      step      = STEP_TABLE[{pair_ff, pair_new}];
      gap       = sample.now_ms - last_time_ff;
      take_step = (step != STEP_NONE) && (gap > TIME_BITS'(cfg.debounce_ms));

      pair_in      = pair_new;
      count_in     = count_ff;
      dir_in       = dir_ff;
      last_time_in = last_time_ff;
      if (take_step) begin
         last_time_in = sample.now_ms;
         if (step == STEP_UP) begin
            count_in = count_ff + POSITION_BITS'(1);
            dir_in   = DIR_CW;
         end else begin
            count_in = count_ff - POSITION_BITS'(1);
            dir_in   = DIR_CCW;
         end
      end else if (gap > TIME_BITS'(cfg.idle_ms)) begin
         // an accepted step leaves a zero gap, so only this branch can time out
         dir_in = DIR_NONE;
      end

      last_sw_in = last_sw_ff;
      held_in    = held_ff;
      if (sample.switch_level != last_sw_ff) begin
         last_sw_in = sample.switch_level;
         held_in    = !sample.switch_level;
      end

      fresh       = 1'b0;
      reported_in = reported_ff;
      if (sample.poll_press) begin
         fresh       = held_in && !reported_ff;
         reported_in = held_in;
      end

      result.position    = RSP_POS_BITS'(count_in);
      result.direction   = dir_in;
      result.button_held = held_in;
      result.new_press   = fresh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff      <= 2'b11;
         count_ff     <= '0;
         dir_ff       <= DIR_NONE;
         last_time_ff <= '0;
         last_sw_ff   <= 1'b1;
         held_ff      <= 1'b0;
         reported_ff  <= 1'b0;
      end else if (sample_valid) begin
         pair_ff      <= pair_in;
         count_ff     <= count_in;
         dir_ff       <= dir_in;
         last_time_ff <= last_time_in;
         last_sw_ff   <= last_sw_in;
         held_ff      <= held_in;
         reported_ff  <= reported_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/quadrature_encoder_with_button.sv]
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button
// rotary encoder decoder with debounced steps, idle timeout and push button
// ----------------------------------------------------------------------------
// Each req transaction carries one sample of the two encoder phases, the
// active-low switch and a millisecond timestamp, and yields exactly one rsp
// transaction with the updated position, direction, held flag and press edge.
// The block takes one transaction per clock while req_tready is high: the
// whole state update is one pass of logic (table lookup, one add, two
// compares) ahead of a result register that drives rsp_tvalid and rsp_tdata. A
// one-entry skid stage behind the result register lets one more transaction
// in while rsp_tready is low; req_tready drops only when that skid entry is
// also full. The configuration port is always ready and should be written
// between items; unknown register indexes are ignored. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_encoder_with_button
   import qeb_pkg::*;
#(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // sample input
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // phase_a[0], phase_b[1], switch_level[2], now_ms[34:3], poll_press[35], zero[39:36]
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // result output
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // position[31:0], direction[33:32], button_held[34], new_press[35], zero[39:36]
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CFG_BITS-1:0]      csr_data
);

   qeb_sample_type sample;
   qeb_cfg_type    cfg_ff, cfg_in;
   qeb_result_type result;
   logic           req_accept;

   // output register and skid entry
   logic           out_valid_ff, out_valid_in;
   qeb_result_type out_data_ff, out_data_in;
   logic           skid_valid_ff, skid_valid_in;
   qeb_result_type skid_data_ff, skid_data_in;

   // unpack the request fields
   assign sample.phase_a      = req_tdata[0];
   assign sample.phase_b      = req_tdata[1];
   assign sample.switch_level = req_tdata[2];
   assign sample.now_ms       = req_tdata[34:3];
   assign sample.poll_press   = req_tdata[35];

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ms = csr_data;
            CSR_IDLE:     cfg_in.idle_ms     = csr_data;
            default:      cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms <= CFG_BITS'(2);
         cfg_ff.idle_ms     <= CFG_BITS'(40);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decoder state and update
   qeb_core #(
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .sample_valid (req_accept),
      .sample       (sample),
      .cfg          (cfg_ff),
      .result       (result)
   );

   // result register with skid entry, order kept: skid drains first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_accept;
            out_data_in  = result;
         end
      end else if (req_accept) begin
         // output stalled, park the new transaction
         skid_valid_in = 1'b1;
         skid_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // pack the response fields
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_tdata[31:0]   = out_data_ff.position;
   assign rsp_tdata[33:32]  = out_data_ff.direction;
   assign rsp_tdata[34]     = out_data_ff.button_held;
   assign rsp_tdata[35]     = out_data_ff.new_press;
   assign rsp_tdata[39:36]  = 4'd0;

endmodule

`default_nettype wire

[rtl/core/qeb_checker.sv]
// ----------------------------------------------------------------------------
// qeb_checker
// port-level checks of the quadrature encoder with button block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qeb_checker
   import qeb_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // no result comes out of nothing right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid right after reset");

   // direction code is none, clockwise or counter-clockwise
   a_dir_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'b11)
      else $error("bad direction code");

   // a reported press edge needs the button held
   a_press_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[34])
      else $error("new_press without button_held");

endmodule

bind quadrature_encoder_with_button qeb_checker u_qeb_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the quadrature encoder with button block
// ----------------------------------------------------------------------------
// A behavioral predictor tracks the phase pair, position, direction, debounce
// timing and button state of the block. Each accepted sample transaction is
// run through it and the expected result is queued; a checker compares every
// result transaction field by field against the oldest expected entry.
// Directed tests cover the reset state, steps in both directions, debounce and
// idle boundaries, invalid transitions, press edge reporting and time wrap;
// random phases then sweep several register settings with random idling on
// both sides, a long result stall and a final stretch with no idling.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
   import qeb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned PRINT_LIMIT  = 40;
   // indexes the block has no register for
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_3 = 2'd3;

   // step for {old pair, new pair}, phase a as the high bit of a pair
   localparam int PHASE_STEP [0:15] = '{
       0, -1,  1,  0,
       1,  0,  0, -1,
      -1,  0,  0,  1,
       0,  1, -1,  0
   };

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CFG_BITS-1:0]      csr_data;

   quadrature_encoder_with_button u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ------------------------------------------------------------------
   // predictor state, a private copy of the block's registers
   // ------------------------------------------------------------------
   logic [CFG_BITS-1:0]  cfg_debounce_ms = 16'd2;
   logic [CFG_BITS-1:0]  cfg_idle_ms     = 16'd40;
   logic [1:0]           prev_pair       = 2'b11;
   logic [31:0]          step_position   = '0;
   qeb_dir_type          turn_dir        = DIR_NONE;
   logic [TIME_BITS-1:0] step_time_ms    = '0;
   logic                 prev_switch     = 1'b1;
   logic                 held_state      = 1'b0;
   logic                 press_reported  = 1'b0;

   // expected result transactions, oldest first
   qeb_result_type expected_results [$];

   // stimulus generator state, follows what was last sent
   logic [1:0]           gen_pair   = 2'b11;
   logic [TIME_BITS-1:0] gen_now    = '0;
   logic                 gen_switch = 1'b1;
   logic                 gen_cw     = 1'b1;

   // idling controls
   int unsigned tx_gap_pct      = 0;
   bit          rx_idle_on      = 1'b0;
   int unsigned long_hold_cycles = 0;

   int unsigned error_count  = 0;
   int unsigned result_count = 0;
   int unsigned cycle_count  = 0;

   // ------------------------------------------------------------------
   // clock and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("quadrature_encoder_with_button test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------
   function automatic qeb_result_type predict_result(input qeb_sample_type s);
      qeb_result_type       r;
      logic [1:0]           pair;
      int                   move;
      logic [TIME_BITS-1:0] gap_ms;
      logic                 fresh;
      pair  = {s.phase_a, s.phase_b};
      move  = PHASE_STEP[{prev_pair, pair}];
      fresh = 1'b0;
      prev_pair = pair;
      // a step counts only when strictly more than the debounce time passed
      gap_ms = s.now_ms - step_time_ms;
      if (move != 0 && gap_ms > {16'd0, cfg_debounce_ms}) begin
         if (move > 0) begin
            step_position = step_position + 32'd1;
            turn_dir      = DIR_CW;
         end else begin
            step_position = step_position - 32'd1;
            turn_dir      = DIR_CCW;
         end
         step_time_ms = s.now_ms;
      end
      gap_ms = s.now_ms - step_time_ms;
      if (gap_ms > {16'd0, cfg_idle_ms}) turn_dir = DIR_NONE;
      if (s.switch_level != prev_switch) begin
         prev_switch = s.switch_level;
         held_state  = ~s.switch_level;
      end
      if (s.poll_press) begin
         fresh          = held_state & ~press_reported;
         press_reported = held_state;
      end
      r.position    = step_position;
      r.direction   = turn_dir;
      r.button_held = held_state;
      r.new_press   = fresh;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // mismatch reporting and result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  result_count, what, got, want);
   endtask

   always @(posedge clock) begin
      qeb_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[31:0], '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[31:0] !== want.position)
               report_mismatch("position", rsp_tdata[31:0], want.position);
            if (rsp_tdata[33:32] !== want.direction)
               report_mismatch("direction", 32'(rsp_tdata[33:32]),
                               32'(want.direction));
            if (rsp_tdata[34] !== want.button_held)
               report_mismatch("button_held", 32'(rsp_tdata[34]),
                               32'(want.button_held));
            if (rsp_tdata[35] !== want.new_press)
               report_mismatch("new_press", 32'(rsp_tdata[35]),
                               32'(want.new_press));
         end
         result_count++;
      end
   end

   // ------------------------------------------------------------------
   // result side: random stall bursts, quiet stretches and long holds
   // ------------------------------------------------------------------
   initial begin
      int unsigned pick;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 15);
         if (long_hold_cycles != 0) begin
            // hold off long enough for the block to fill and stall its input
            rsp_tready <= 1'b0;
            repeat (long_hold_cycles) @(posedge clock);
            long_hold_cycles = 0;
         end else if (rx_idle_on && pick == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else if (pick == 1) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------
   // sample side
   // ------------------------------------------------------------------
   function automatic qeb_sample_type make_sample(input logic a, input logic b,
                                                  input logic sw,
                                                  input logic [31:0] now,
                                                  input logic poll);
      qeb_sample_type s;
      s.phase_a      = a;
      s.phase_b      = b;
      s.switch_level = sw;
      s.now_ms       = now;
      s.poll_press   = poll;
      return s;
   endfunction

   // sends one sample transaction and queues its expected result
   task automatic send_sample(input qeb_sample_type s);
      if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, s.poll_press, s.now_ms, s.switch_level, s.phase_b, s.phase_a};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_result(s));
      gen_pair   = {s.phase_a, s.phase_b};
      gen_now    = s.now_ms;
      gen_switch = s.switch_level;
   endtask

   // sender pauses until every expected result transaction has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // leaves csr_valid high so writes can follow back to back
   task automatic write_register(input logic [CSR_IDX_BITS-1:0] idx,
                                 input logic [CFG_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE: cfg_debounce_ms = value;
         CSR_IDLE:     cfg_idle_ms     = value;
         default:      ;
      endcase
   endtask

   task automatic apply_setting(input logic [CFG_BITS-1:0] debounce_ms,
                                input logic [CFG_BITS-1:0] idle_ms);
      drain_results();
      write_register(CSR_DEBOUNCE, debounce_ms);
      write_register(CSR_IDLE, idle_ms);
      csr_valid <= 1'b0;
   endtask

   // next pair along a clockwise (3,1,0,2) or counter-clockwise turn
   function automatic logic [1:0] turn_next(input logic [1:0] p, input logic cw);
      logic [1:0] n;
      case (p)
         2'b11:   n = cw ? 2'b01 : 2'b10;
         2'b01:   n = cw ? 2'b00 : 2'b11;
         2'b00:   n = cw ? 2'b10 : 2'b01;
         default: n = cw ? 2'b11 : 2'b00;
      endcase
      return n;
   endfunction

   // mostly well-formed rotation with timing around the register values
   function automatic qeb_sample_type random_sample();
      int unsigned          pick;
      logic [1:0]           pair;
      logic [TIME_BITS-1:0] now;
      logic                 sw;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) gen_cw = ~gen_cw;
      if (pick < 70)      pair = turn_next(gen_pair, gen_cw);
      else if (pick < 80) pair = gen_pair;
      else if (pick < 90) pair = ~gen_pair;
      else                pair = 2'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 50)      now = gen_now + $urandom_range(0, cfg_debounce_ms + 2);
      else if (pick < 80) now = gen_now + $urandom_range(0, cfg_idle_ms + 3);
      else if (pick < 95) now = gen_now + $urandom_range(0, 100);
      else if (pick < 98) now = $urandom;
      else                now = gen_now + 32'd65536 + $urandom_range(0, 3);
      sw = ($urandom_range(0, 7) == 0) ? ~gen_switch : gen_switch;
      return make_sample(pair[1], pair[0], sw, now, $urandom_range(0, 2) == 0);
   endfunction

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         // change the sender's idling every chunk so quiet stretches occur
         if (i % 64 == 0 && rx_idle_on) begin
            case ($urandom_range(0, 2))
               0:       tx_gap_pct = 0;
               1:       tx_gap_pct = 15;
               default: tx_gap_pct = 40;
            endcase
         end
         send_sample(random_sample());
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_state();
      // idle high phases and released switch, then an invalid jump to 00
      send_sample(make_sample(1'b1, 1'b1, 1'b1, 32'd0, 1'b1));
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd100, 1'b0));
   endtask

   task automatic test_steps_and_debounce();
      send_sample(make_sample(1'b1, 1'b1, 1'b1, 32'd100, 1'b0)); // invalid back to 11
      send_sample(make_sample(1'b0, 1'b1, 1'b1, 32'd100, 1'b0)); // cw accepted
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd102, 1'b0)); // gap equals debounce
      send_sample(make_sample(1'b1, 1'b0, 1'b1, 32'd103, 1'b0)); // cw accepted
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd104, 1'b0)); // ccw rejected
      send_sample(make_sample(1'b0, 1'b1, 1'b1, 32'd110, 1'b0)); // ccw accepted
      send_sample(make_sample(1'b1, 1'b1, 1'b1, 32'd111, 1'b0)); // ccw rejected
      send_sample(make_sample(1'b1, 1'b0, 1'b1, 32'd120, 1'b0)); // ccw to zero
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd130, 1'b0)); // wraps below zero
      // idle boundary: equal keeps the direction, one more clears it
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd170, 1'b0));
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd171, 1'b0));
   endtask

   task automatic test_button();
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'd200, 1'b0)); // press, no poll
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'd201, 1'b1)); // edge reported
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'd202, 1'b1)); // reported once only
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd203, 1'b1)); // release clears report
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'd204, 1'b1)); // second press
      send_sample(make_sample(1'b0, 1'b0, 1'b1, 32'd205, 1'b0)); // release, no poll
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'd206, 1'b1)); // no edge, report flag never cleared
   endtask

   task automatic test_time_wrap();
      send_sample(make_sample(1'b1, 1'b0, 1'b1, 32'hFFFF_FFFE, 1'b0));
      send_sample(make_sample(1'b1, 1'b1, 1'b1, 32'h0000_0001, 1'b1)); // across wrap
      send_sample(make_sample(1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0)); // backwards
      send_sample(make_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1));
   endtask

   task automatic test_spare_registers();
      // writes to indexes without a register must leave the settings alone
      drain_results();
      write_register(CSR_SPARE_2, 16'h0000);
      write_register(CSR_SPARE_3, 16'hFFFF);
      csr_valid <= 1'b0;
      send_random(30);
   endtask

   task automatic test_setting_sweep();
      logic [CFG_BITS-1:0] debounce_set [7];
      logic [CFG_BITS-1:0] idle_set [7];
      debounce_set = '{16'd0, 16'hFFFF, 16'd0,     16'hFFFF, 16'd1, 16'd0, 16'd2};
      idle_set     = '{16'd0, 16'hFFFF, 16'hFFFF,  16'd0,    16'd5, 16'd0, 16'd40};
      debounce_set[5] = CFG_BITS'($urandom_range(0, 65535));
      idle_set[5]     = CFG_BITS'($urandom_range(0, 65535));
      for (int k = 0; k < 7; k++) begin
         apply_setting(debounce_set[k], idle_set[k]);
         send_random(200);
      end
   endtask

   task automatic test_backpressure();
      int unsigned saved_gap;
      saved_gap  = tx_gap_pct;
      tx_gap_pct = 0;
      // result side stops for a long stretch while samples keep coming
      drain_results();
      long_hold_cycles = 300;
      do @(posedge clock); while (rsp_tready);
      send_random(40);
      drain_results();
      tx_gap_pct = saved_gap;
      send_random(40);
   endtask

   task automatic test_no_idling();
      drain_results();
      tx_gap_pct = 0;
      rx_idle_on = 1'b0;
      send_random(150);
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DEBOUNCE;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_steps_and_debounce();
      test_button();
      test_time_wrap();

      rx_idle_on = 1'b1;
      tx_gap_pct = 15;
      test_spare_registers();
      test_setting_sweep();
      test_backpressure();
      test_no_idling();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("quadrature_encoder_with_button test passed");
      end else begin
         $display("quadrature_encoder_with_button test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
